// File: sv/cahvor_vanishing_point_project_unit_defines.svh
// Assertion macros shared by the vanishing-point projector RTL.
`ifndef CAHVOR_VANISHING_POINT_PROJECT_UNIT_DEFINES_SVH
`define CAHVOR_VANISHING_POINT_PROJECT_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define CVP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CVP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/cvp_pkg.sv
// Types, widths and helpers for the vanishing-point projector.
`timescale 1ns / 1ps
`default_nettype none

package cvp_pkg;

  localparam int FRAC_BITS_OUT = 8;

  localparam int COMP_W    = 21;
  localparam int VEC_W     = 3 * COMP_W;
  localparam int LOOK_W    = 24;
  localparam int RAD_W     = 32;
  localparam int POS_W     = 32;
  localparam int CFG_IDX_W = 3;

  localparam int OMEGA_W = 29;
  localparam int LAM_W   = 32;
  localparam int LSQ_W   = 56;
  localparam int TAU_W   = 27;
  localparam int MU_W    = 34;
  localparam int P_W     = 46;
  localparam int DOT_W   = 64;
  localparam int MAG_W   = 62;

  // quotient < 2^31 iff |num| < |alpha| * 2^(20 - frac bits)
  localparam int DIV_SHIFT = 20 - FRAC_BITS_OUT;
  localparam int PDEN_W    = MAG_W + DIV_SHIFT;
  localparam int QPOS_W    = POS_W - 1;

  // z component = 1.0 in Q1.19
  localparam logic [VEC_W-1:0] UNIT_Z_VEC = VEC_W'(1) << (2 * COMP_W + 19);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS  = 3'd0,
    REG_OPT   = 3'd1,
    REG_HORIZ = 3'd2,
    REG_VERT  = 3'd3,
    REG_K0    = 3'd4,
    REG_K1    = 3'd5,
    REG_K2    = 3'd6
  } cfg_reg_e;

  typedef logic [2:0][LOOK_W-1:0] look_vec_t;
  typedef logic [2:0][LAM_W-1:0]  lam_vec_t;

  typedef struct packed {
    logic             bad;
    logic [LSQ_W-1:0] lsq;
    logic [LSQ_W-1:0] dnm;
    lam_vec_t         lam;
    look_vec_t        look;
  } front_t;

  typedef struct packed {
    logic             bad;
    logic [TAU_W-1:0] tau;
    lam_vec_t         lam;
    look_vec_t        look;
  } tau_t;

  typedef struct packed {
    logic             bad;
    logic [DOT_W-1:0] alpha;
    logic [DOT_W-1:0] beta;
    logic [DOT_W-1:0] gamma;
  } dot_t;

  typedef struct packed {
    logic              bad;
    logic              neg_s;
    logic              neg_l;
    logic [QPOS_W-1:0] q_s;
    logic [QPOS_W-1:0] q_l;
  } quot_t;

  function automatic logic signed [COMP_W-1:0] comp(input logic [VEC_W-1:0] v,
                                                    input int k);
    return $signed(v[COMP_W*k +: COMP_W]);
  endfunction

endpackage

`default_nettype wire

// File: sv/cahvor_vanishing_point_project_unit.sv
// Top level of the CAHVOR vanishing-point projector.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+------------------------------------
//   in       | in        | in_valid_i / in_stall_o   | look_x_i, look_y_i, look_z_i
//   out      | out       | out_valid_o / out_stall_i | sample_pos_o, line_pos_o, invalid_o
//   cfg      | in        | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// One transaction per cycle in and out while the output is not stalled; the
// two restoring dividers have 27 stages for tau and 31 for the positions.
// Reset clears the valid bits, loads A and O with unit z and zeroes H, V, k0-k2.
// A stalled result freezes the whole pipe; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "cahvor_vanishing_point_project_unit_defines.svh"

module cahvor_vanishing_point_project_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cvp_pkg::LOOK_W-1:0]    look_x_i,
  input  logic [cvp_pkg::LOOK_W-1:0]    look_y_i,
  input  logic [cvp_pkg::LOOK_W-1:0]    look_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cvp_pkg::POS_W-1:0]     sample_pos_o,
  output logic [cvp_pkg::POS_W-1:0]     line_pos_o,
  output logic                          invalid_o,
  input  logic                          cfg_we_i,
  input  logic [cvp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [cvp_pkg::VEC_W-1:0]     cfg_data_i
);
  import cvp_pkg::*;

  // configuration registers
  logic [VEC_W-1:0] axis_q, opt_q, horiz_q, vert_q;
  logic [RAD_W-1:0] k0_q, k1_q, k2_q;

  // whole pipe moves unless a finished result is held
  logic      adv;
  look_vec_t look;
  logic      front_valid, tau_valid, dot_valid, quot_valid;
  front_t    front;
  tau_t      tau;
  dot_t      dot;
  quot_t     quot;
  logic [POS_W-1:0] s_val, l_val;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign look[0]    = look_x_i;
  assign look[1]    = look_y_i;
  assign look[2]    = look_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q  <= UNIT_Z_VEC;
      opt_q   <= UNIT_Z_VEC;
      horiz_q <= '0;
      vert_q  <= '0;
      k0_q    <= '0;
      k1_q    <= '0;
      k2_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_AXIS:  axis_q  <= cfg_data_i;
        REG_OPT:   opt_q   <= cfg_data_i;
        REG_HORIZ: horiz_q <= cfg_data_i;
        REG_VERT:  vert_q  <= cfg_data_i;
        REG_K0:    k0_q    <= cfg_data_i[RAD_W-1:0];
        REG_K1:    k1_q    <= cfg_data_i[RAD_W-1:0];
        REG_K2:    k2_q    <= cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // omega, lambda, |lambda|^2 (6 stages)
  cvp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .look_i  (look),
    .opt_i   (opt_q),
    .valid_o (front_valid),
    .front_o (front)
  );

  // tau = |lambda|^2 / omega^2 (27 stages)
  cvp_tau_div u_tau_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (front_valid),
    .front_i (front),
    .valid_o (tau_valid),
    .tau_o   (tau)
  );

  // mu, p and the three dot products (8 stages)
  cvp_distort u_distort (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (tau_valid),
    .tau_i   (tau),
    .k0_i    (k0_q),
    .k1_i    (k1_q),
    .k2_i    (k2_q),
    .axis_i  (axis_q),
    .horiz_i (horiz_q),
    .vert_i  (vert_q),
    .valid_o (dot_valid),
    .dot_o   (dot)
  );

  // range check plus sample and line quotients (32 stages)
  cvp_pos_div u_pos_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (dot_valid),
    .dot_i   (dot),
    .valid_o (quot_valid),
    .quot_o  (quot)
  );

  // sign back on; a failed projection reports zero positions
  always_comb begin
    s_val = quot.neg_s ? -POS_W'(quot.q_s) : POS_W'(quot.q_s);
    l_val = quot.neg_l ? -POS_W'(quot.q_l) : POS_W'(quot.q_l);
    if (quot.bad) begin
      s_val = '0;
      l_val = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= quot_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sample_pos_o <= s_val;
      line_pos_o   <= l_val;
      invalid_o    <= quot.bad;
    end
  end

  `CVP_ASSERT_SAME(a_inv_zero, out_valid_o && invalid_o, sample_pos_o == '0 && line_pos_o == '0, "invalid result carries a position")
  `CVP_ASSERT_NEXT(a_bad_flag, adv && quot_valid && quot.bad, out_valid_o && invalid_o, "failed projection not flagged")
  `CVP_ASSERT_NEXT(a_freeze, !adv, $stable(front_valid) && $stable(quot_valid), "pipe moved while output held")

endmodule

`default_nettype wire

// File: sv/cvp_front.sv
// Front stages: omega, lambda, |lambda|^2 and the tau divisor.
`timescale 1ns / 1ps
`default_nettype none

module cvp_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  cvp_pkg::look_vec_t        look_i,
  input  logic [cvp_pkg::VEC_W-1:0] opt_i,
  output logic                      valid_o,
  output cvp_pkg::front_t           front_o
);
  import cvp_pkg::*;

  localparam int PO_W   = LOOK_W + COMP_W;
  localparam int OM40_W = PO_W + 3;
  localparam int OO_W   = COMP_W + OMEGA_W;
  localparam int SQ_W   = 2 * LAM_W;
  localparam int OSQ_W  = 2 * OMEGA_W;

  localparam logic signed [OM40_W-1:0] HALF_OM = OM40_W'(1) <<< 18;
  localparam logic signed [OO_W-1:0]   HALF_OO = OO_W'(1) <<< 18;

  logic [4:0] v_q;

  logic signed [PO_W-1:0]    po_q [3];
  logic signed [PO_W-1:0]    po_d [3];
  logic signed [OMEGA_W-1:0] omega2_q, omega3_q, omega4_q;
  logic signed [OMEGA_W-1:0] omega2_d;
  logic signed [OM40_W-1:0]  om_sum;
  logic signed [OO_W-1:0]    oo_q [3];
  logic signed [OO_W-1:0]    oo_d [3];
  logic signed [LAM_W-1:0]   lam4_q [3];
  logic signed [LAM_W-1:0]   lam4_d [3];
  logic signed [SQ_W-1:0]    sq_full [3];
  logic [LSQ_W-1:0]          sq_q [3];
  logic [LSQ_W-1:0]          sq_d [3];
  logic signed [OSQ_W-1:0]   osq_full;
  logic [LSQ_W-1:0]          osq_q;
  lam_vec_t                  lam5_q;
  look_vec_t                 look1_q, look2_q, look3_q, look4_q, look5_q;
  logic [LSQ_W-1:0]          lsq_d, dnm_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      po_d[i] = PO_W'($signed(look_i[i])) * PO_W'(comp(opt_i, i));
    end
    om_sum   = OM40_W'(po_q[0]) + OM40_W'(po_q[1]) + OM40_W'(po_q[2]) + HALF_OM;
    omega2_d = OMEGA_W'(om_sum >>> 19);
    for (int i = 0; i < 3; i++) begin
      oo_d[i]    = OO_W'(comp(opt_i, i)) * OO_W'(omega2_q);
      lam4_d[i]  = LAM_W'($signed(look3_q[i])) - LAM_W'((oo_q[i] + HALF_OO) >>> 19);
      sq_full[i] = SQ_W'(lam4_q[i]) * SQ_W'(lam4_q[i]);
      sq_d[i]    = LSQ_W'(sq_full[i]);
    end
    osq_full = OSQ_W'(omega4_q) * OSQ_W'(omega4_q);
    lsq_d    = sq_q[0] + sq_q[1] + sq_q[2];
    dnm_d    = osq_q << 3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      valid_o <= 1'b0;
    end else if (adv_i) begin
      v_q     <= {v_q[3:0], valid_i};
      valid_o <= v_q[4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      po_q     <= po_d;
      look1_q  <= look_i;
      omega2_q <= omega2_d;
      look2_q  <= look1_q;
      oo_q     <= oo_d;
      omega3_q <= omega2_q;
      look3_q  <= look2_q;
      lam4_q   <= lam4_d;
      omega4_q <= omega3_q;
      look4_q  <= look3_q;
      sq_q     <= sq_d;
      osq_q    <= LSQ_W'(osq_full);
      for (int i = 0; i < 3; i++) begin
        lam5_q[i] <= lam4_q[i];
      end
      look5_q  <= look4_q;
      // zero omega gives a zero divisor, caught by the same compare
      front_o.bad  <= (lsq_d >= dnm_d);
      front_o.lsq  <= lsq_d;
      front_o.dnm  <= dnm_d;
      front_o.lam  <= lam5_q;
      front_o.look <= look5_q;
    end
  end

endmodule

`default_nettype wire

// File: sv/cvp_tau_div.sv
// Pipelined restoring divider for tau, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module cvp_tau_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  cvp_pkg::front_t front_i,
  output logic            valid_o,
  output cvp_pkg::tau_t   tau_o
);
  import cvp_pkg::*;

  typedef struct packed {
    logic             bad;
    logic [LSQ_W-1:0] rem;
    logic [LSQ_W-1:0] dnm;
    logic [TAU_W-1:0] q;
    lam_vec_t         lam;
    look_vec_t        look;
  } tstep_t;

  logic [TAU_W-1:0] v_q;
  tstep_t           st_q   [TAU_W];
  tstep_t           st_in  [TAU_W];
  tstep_t           st_nxt [TAU_W];
  logic [LSQ_W:0]   dbl    [TAU_W];
  logic             ge     [TAU_W];

  always_comb begin
    st_in[0].bad  = front_i.bad;
    st_in[0].rem  = front_i.lsq;
    st_in[0].dnm  = front_i.dnm;
    st_in[0].q    = '0;
    st_in[0].lam  = front_i.lam;
    st_in[0].look = front_i.look;
    for (int k = 1; k < TAU_W; k++) begin
      st_in[k] = st_q[k-1];
    end
    for (int k = 0; k < TAU_W; k++) begin
      dbl[k]        = {st_in[k].rem, 1'b0};
      ge[k]         = dbl[k] >= {1'b0, st_in[k].dnm};
      st_nxt[k]     = st_in[k];
      st_nxt[k].rem = ge[k] ? LSQ_W'(dbl[k] - {1'b0, st_in[k].dnm}) : LSQ_W'(dbl[k]);
      st_nxt[k].q   = {st_in[k].q[TAU_W-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[TAU_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < TAU_W; k++) begin
        st_q[k] <= st_nxt[k];
      end
    end
  end

  assign valid_o    = v_q[TAU_W-1];
  assign tau_o.bad  = st_q[TAU_W-1].bad;
  assign tau_o.tau  = st_q[TAU_W-1].q;
  assign tau_o.lam  = st_q[TAU_W-1].lam;
  assign tau_o.look = st_q[TAU_W-1].look;

endmodule

`default_nettype wire

// File: sv/cvp_distort.sv
// Radial distortion polynomial, distorted ray and its dot products with A, H, V.
`timescale 1ns / 1ps
`default_nettype none

module cvp_distort (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  cvp_pkg::tau_t             tau_i,
  input  logic [cvp_pkg::RAD_W-1:0] k0_i,
  input  logic [cvp_pkg::RAD_W-1:0] k1_i,
  input  logic [cvp_pkg::RAD_W-1:0] k2_i,
  input  logic [cvp_pkg::VEC_W-1:0] axis_i,
  input  logic [cvp_pkg::VEC_W-1:0] horiz_i,
  input  logic [cvp_pkg::VEC_W-1:0] vert_i,
  output logic                      valid_o,
  output cvp_pkg::dot_t             dot_o
);
  import cvp_pkg::*;

  localparam int TSQ_W  = 2 * TAU_W;
  localparam int TAU2_W = TSQ_W - 24 + 1;
  localparam int M1_W   = RAD_W + TAU_W + 1;
  localparam int M2_W   = RAD_W + TAU2_W + 1;
  localparam int ACC_W  = M2_W + 2;
  localparam int LM_W   = LAM_W + MU_W;
  localparam int PR_W   = P_W + COMP_W;
  localparam int SUM_W  = PR_W + 2;

  localparam logic [TSQ_W:0]          HALF_T  = (TSQ_W + 1)'(1) << 23;
  localparam logic signed [ACC_W-1:0] HALF_MU = ACC_W'(1) <<< 30;
  localparam logic signed [LM_W-1:0]  HALF_LM = LM_W'(1) <<< 20;

  logic [6:0] v_q;
  logic [6:0] bad_q;

  logic [TSQ_W-1:0]         tsq_q;
  logic [TAU_W-1:0]         tau1_q, tau2_in_q;
  logic [TAU2_W-1:0]        tau2_q;
  logic [TSQ_W:0]           tsq_rnd;
  logic signed [M1_W-1:0]   m1_q;
  logic signed [M2_W-1:0]   m2_q;
  logic signed [ACC_W-1:0]  acc;
  logic signed [MU_W-1:0]   mu_q;
  logic signed [LM_W-1:0]   lm_q [3];
  logic signed [P_W-1:0]    p_q  [3];
  logic signed [PR_W-1:0]   pa_q [3];
  logic signed [PR_W-1:0]   ph_q [3];
  logic signed [PR_W-1:0]   pv_q [3];
  logic signed [SUM_W-1:0]  sa, sb, sg;
  lam_vec_t                 lam1_q, lam2_q, lam3_q, lam4_q;
  look_vec_t                look1_q, look2_q, look3_q, look4_q, look5_q;

  assign tsq_rnd = {1'b0, tsq_q} + HALF_T;
  assign acc     = (ACC_W'($signed(k0_i)) <<< 24) + ACC_W'(m1_q) + ACC_W'(m2_q) + HALF_MU;
  assign sa      = SUM_W'(pa_q[0]) + SUM_W'(pa_q[1]) + SUM_W'(pa_q[2]);
  assign sb      = SUM_W'(ph_q[0]) + SUM_W'(ph_q[1]) + SUM_W'(ph_q[2]);
  assign sg      = SUM_W'(pv_q[0]) + SUM_W'(pv_q[1]) + SUM_W'(pv_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      valid_o <= 1'b0;
    end else if (adv_i) begin
      v_q     <= {v_q[5:0], valid_i};
      valid_o <= v_q[6];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      bad_q   <= {bad_q[5:0], tau_i.bad};
      // tau^2, then rounded to 24 fraction bits
      tsq_q     <= TSQ_W'(tau_i.tau) * TSQ_W'(tau_i.tau);
      tau1_q    <= tau_i.tau;
      lam1_q    <= tau_i.lam;
      look1_q   <= tau_i.look;
      tau2_q    <= TAU2_W'(tsq_rnd >> 24);
      tau2_in_q <= tau1_q;
      lam2_q    <= lam1_q;
      look2_q   <= look1_q;
      m1_q      <= M1_W'($signed(k1_i)) * $signed(M1_W'(tau2_in_q));
      m2_q      <= M2_W'($signed(k2_i)) * $signed(M2_W'(tau2_q));
      lam3_q    <= lam2_q;
      look3_q   <= look2_q;
      mu_q      <= MU_W'(acc >>> 31);
      lam4_q    <= lam3_q;
      look4_q   <= look3_q;
      for (int i = 0; i < 3; i++) begin
        lm_q[i] <= LM_W'($signed(lam4_q[i])) * LM_W'(mu_q);
        p_q[i]  <= P_W'((lm_q[i] + HALF_LM) >>> 21) + P_W'($signed(look5_q[i]));
        pa_q[i] <= PR_W'(p_q[i]) * PR_W'(comp(axis_i, i));
        ph_q[i] <= PR_W'(p_q[i]) * PR_W'(comp(horiz_i, i));
        pv_q[i] <= PR_W'(p_q[i]) * PR_W'(comp(vert_i, i));
      end
      look5_q     <= look4_q;
      dot_o.bad   <= bad_q[6];
      dot_o.alpha <= DOT_W'(sa);
      dot_o.beta  <= DOT_W'(sb);
      dot_o.gamma <= DOT_W'(sg);
    end
  end

endmodule

`default_nettype wire

// File: sv/cvp_pos_div.sv
// Range check and twin pipelined dividers for sample and line.
`timescale 1ns / 1ps
`default_nettype none

module cvp_pos_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  cvp_pkg::dot_t  dot_i,
  output logic           valid_o,
  output cvp_pkg::quot_t quot_o
);
  import cvp_pkg::*;

  typedef struct packed {
    logic              bad;
    logic              neg_s;
    logic              neg_l;
    logic [PDEN_W-1:0] rem_s;
    logic [PDEN_W-1:0] rem_l;
    logic [PDEN_W-1:0] dnm;
    logic [QPOS_W-1:0] q_s;
    logic [QPOS_W-1:0] q_l;
  } pstep_t;

  logic              pre_v_q;
  pstep_t            pre_q;
  logic [MAG_W-1:0]  ma, mb, mg;
  logic [PDEN_W-1:0] dden;

  logic [QPOS_W-1:0] v_q;
  pstep_t            st_q   [QPOS_W];
  pstep_t            st_in  [QPOS_W];
  pstep_t            st_nxt [QPOS_W];
  logic [PDEN_W:0]   dbl_s  [QPOS_W];
  logic [PDEN_W:0]   dbl_l  [QPOS_W];
  logic              ge_s   [QPOS_W];
  logic              ge_l   [QPOS_W];

  always_comb begin
    ma   = dot_i.alpha[DOT_W-1] ? MAG_W'(-dot_i.alpha) : MAG_W'(dot_i.alpha);
    mb   = dot_i.beta[DOT_W-1]  ? MAG_W'(-dot_i.beta)  : MAG_W'(dot_i.beta);
    mg   = dot_i.gamma[DOT_W-1] ? MAG_W'(-dot_i.gamma) : MAG_W'(dot_i.gamma);
    dden = PDEN_W'(ma) << DIV_SHIFT;
  end

  always_comb begin
    st_in[0] = pre_q;
    for (int k = 1; k < QPOS_W; k++) begin
      st_in[k] = st_q[k-1];
    end
    for (int k = 0; k < QPOS_W; k++) begin
      dbl_s[k]        = {st_in[k].rem_s, 1'b0};
      dbl_l[k]        = {st_in[k].rem_l, 1'b0};
      ge_s[k]         = dbl_s[k] >= {1'b0, st_in[k].dnm};
      ge_l[k]         = dbl_l[k] >= {1'b0, st_in[k].dnm};
      st_nxt[k]       = st_in[k];
      st_nxt[k].rem_s = ge_s[k] ? PDEN_W'(dbl_s[k] - {1'b0, st_in[k].dnm})
                                : PDEN_W'(dbl_s[k]);
      st_nxt[k].rem_l = ge_l[k] ? PDEN_W'(dbl_l[k] - {1'b0, st_in[k].dnm})
                                : PDEN_W'(dbl_l[k]);
      st_nxt[k].q_s   = {st_in[k].q_s[QPOS_W-2:0], ge_s[k]};
      st_nxt[k].q_l   = {st_in[k].q_l[QPOS_W-2:0], ge_l[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_v_q <= 1'b0;
      v_q     <= '0;
    end else if (adv_i) begin
      pre_v_q <= valid_i;
      v_q     <= {v_q[QPOS_W-2:0], pre_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      // upstream failure, zero alpha, or either quotient at 2^31 or above
      pre_q.bad   <= dot_i.bad || (ma == '0) ||
                     (PDEN_W'(mb) >= dden) || (PDEN_W'(mg) >= dden);
      pre_q.neg_s <= dot_i.beta[DOT_W-1] ^ dot_i.alpha[DOT_W-1];
      pre_q.neg_l <= dot_i.gamma[DOT_W-1] ^ dot_i.alpha[DOT_W-1];
      pre_q.rem_s <= PDEN_W'(mb);
      pre_q.rem_l <= PDEN_W'(mg);
      pre_q.dnm   <= dden;
      pre_q.q_s   <= '0;
      pre_q.q_l   <= '0;
      for (int k = 0; k < QPOS_W; k++) begin
        st_q[k] <= st_nxt[k];
      end
    end
  end

  assign valid_o      = v_q[QPOS_W-1];
  assign quot_o.bad   = st_q[QPOS_W-1].bad;
  assign quot_o.neg_s = st_q[QPOS_W-1].neg_s;
  assign quot_o.neg_l = st_q[QPOS_W-1].neg_l;
  assign quot_o.q_s   = st_q[QPOS_W-1].q_s;
  assign quot_o.q_l   = st_q[QPOS_W-1].q_l;

endmodule

`default_nettype wire
